/* rtl/core/rvde_pkg.sv */
// shared types, opcodes and constants for the rv32 decode and execute block
package rvde_pkg;

	localparam int RVDE_FIFO_DEPTH = 2;
	localparam int XLEN = 32;

	localparam logic [6:0] OPC_R      = 7'd51;
	localparam logic [6:0] OPC_IMM    = 7'd19;
	localparam logic [6:0] OPC_LOAD   = 7'd3;
	localparam logic [6:0] OPC_STORE  = 7'd35;
	localparam logic [6:0] OPC_BRANCH = 7'd99;
	localparam logic [6:0] OPC_LUI    = 7'd55;
	localparam logic [6:0] OPC_JAL    = 7'd111;
	localparam logic [6:0] OPC_JALR   = 7'd103;

	localparam logic [6:0] F7_BASE = 7'd0;
	localparam logic [6:0] F7_ALT  = 7'd32;
	localparam logic [6:0] F7_MULD = 7'd1;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_ADD2 = 3'd2;
	localparam logic [2:0] F3_BAD  = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [4:0] SHAMT_MASK = 5'h1F;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_OPCODE = 2'd1,
		ERR_FUNCT  = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		ALU_ADD, ALU_SUB, ALU_MUL, ALU_SLL, ALU_XOR,
		ALU_DIV, ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
	} alu_op_t;

	typedef enum logic [2:0] {
		BR_EQ, BR_NE, BR_LT, BR_GE, BR_LTU, BR_GEU
	} br_cond_t;

	typedef struct packed {
		alu_op_t          alu_op;
		logic [XLEN-1:0]  alu_a;
		logic [XLEN-1:0]  alu_b;
		logic             is_branch;
		br_cond_t         br_cond;
		logic             is_jump;
		logic [XLEN-1:0]  target;
		logic [XLEN-1:0]  pc_plus4;
		logic [4:0]       rd;
		logic             writes;
		logic             is_load;
		logic             is_store;
		logic [XLEN-1:0]  store_data;
		err_t             err;
	} rvde_uop_t;

	typedef struct packed {
		logic idle;
		logic done;
	} rvde_div_stat_t;

endpackage

/* rtl/core/rvde_front.sv */
// front part: decodes an instruction beat into a micro-op
module rvde_front import rvde_pkg::*; (
	input  logic [XLEN-1:0] instr_word,
	input  logic [XLEN-1:0] pc_value,
	input  logic [XLEN-1:0] src1_value,
	input  logic [XLEN-1:0] src2_value,
	output rvde_uop_t       uop
);

	logic [6:0]      opc;
	logic [2:0]      f3;
	logic [6:0]      f7;
	logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_j, imm_u;
	logic [XLEN-1:0] pc_plus4, jalr_sum;
	alu_op_t         dec_op;
	logic            dec_bad;

	assign opc   = instr_word[6:0];
	assign f3    = instr_word[14:12];
	assign f7    = instr_word[31:25];
	assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
	assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
	assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
		instr_word[30:25], instr_word[11:8], 1'b0};
	assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
		instr_word[20], instr_word[30:21], 1'b0};
	assign imm_u = {instr_word[31:12], 12'b0};
	assign pc_plus4 = pc_value + XLEN'(4);
	assign jalr_sum = src1_value + imm_i;

	always_comb begin
		logic [6:0] f7_eff;
		f7_eff  = (opc == OPC_R) ? f7 : F7_BASE;
		dec_op  = ALU_ADD;
		dec_bad = 1'b0;
		unique case (f3)
			F3_ADD: begin
				if (f7_eff == F7_BASE) dec_op = ALU_ADD;
				else if (f7_eff == F7_ALT) dec_op = ALU_SUB;
				else if (f7_eff == F7_MULD) dec_op = ALU_MUL;
				else dec_bad = 1'b1;
			end
			F3_SLL:  dec_op = ALU_SLL;
			F3_ADD2: dec_op = ALU_ADD;
			F3_BAD:  dec_bad = 1'b1;
			F3_XOR:  dec_op = (f7_eff == F7_MULD) ? ALU_DIV : ALU_XOR;
			F3_SR:   dec_op = instr_word[30] ? ALU_SRA : ALU_SRL;
			F3_OR:   dec_op = ALU_OR;
			F3_AND:  dec_op = ALU_AND;
			default: dec_bad = 1'b1;
		endcase
	end

	always_comb begin
		uop            = '0;
		uop.alu_op     = ALU_ADD;
		uop.br_cond    = BR_EQ;
		uop.err        = ERR_NONE;
		uop.pc_plus4   = pc_plus4;
		unique case (opc)
			OPC_R, OPC_IMM: begin
				uop.alu_op = dec_op;
				uop.alu_a  = src1_value;
				uop.alu_b  = (opc == OPC_R) ? src2_value : imm_i;
				uop.writes = 1'b1;
				if (dec_bad) uop.err = ERR_FUNCT;
			end
			OPC_LOAD: begin
				uop.alu_a   = src1_value;
				uop.alu_b   = imm_i;
				uop.writes  = 1'b1;
				uop.is_load = 1'b1;
			end
			OPC_STORE: begin
				uop.alu_a      = src1_value;
				uop.alu_b      = imm_s;
				uop.is_store   = 1'b1;
				uop.store_data = src2_value;
			end
			OPC_BRANCH: begin
				uop.alu_a     = src1_value;
				uop.alu_b     = src2_value;
				uop.is_branch = 1'b1;
				uop.target    = pc_value + imm_b;
				unique case (f3)
					F3_BEQ:  uop.br_cond = BR_EQ;
					F3_BNE:  uop.br_cond = BR_NE;
					F3_BLT:  uop.br_cond = BR_LT;
					F3_BGE:  uop.br_cond = BR_GE;
					F3_BLTU: uop.br_cond = BR_LTU;
					F3_BGEU: uop.br_cond = BR_GEU;
					default: uop.err = ERR_FUNCT;
				endcase
			end
			OPC_LUI: begin
				uop.alu_a  = imm_u;
				uop.writes = 1'b1;
			end
			OPC_JAL: begin
				uop.alu_a   = pc_plus4;
				uop.writes  = 1'b1;
				uop.is_jump = 1'b1;
				uop.target  = pc_value + imm_j;
			end
			OPC_JALR: begin
				uop.alu_a   = pc_plus4;
				uop.writes  = 1'b1;
				uop.is_jump = 1'b1;
				uop.target  = {jalr_sum[XLEN-1:1], 1'b0};
			end
			default: uop.err = ERR_OPCODE;
		endcase
		if (uop.err != ERR_NONE) begin
			uop          = '0;
			uop.alu_op   = ALU_ADD;
			uop.br_cond  = BR_EQ;
			uop.pc_plus4 = pc_plus4;
			uop.err      = (opc == OPC_R || opc == OPC_IMM || opc == OPC_BRANCH)
				? ERR_FUNCT : ERR_OPCODE;
		end
		if (uop.writes) uop.rd = instr_word[11:7];
	end

endmodule

/* rtl/core/rvde_fifo.sv */
// micro-op queue between front and back
module rvde_fifo import rvde_pkg::*; #(
	parameter int DEPTH = RVDE_FIFO_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rvde_uop_t in_uop,
	output logic      out_valid,
	input  logic      out_ready,
	output rvde_uop_t out_uop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rvde_uop_t       mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push, pop;

	assign in_ready  = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_uop   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= in_uop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/core/rvde_div.sv */
// bit-serial signed divider, one quotient bit per cycle
module rvde_div import rvde_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            ack,
	input  logic [XLEN-1:0] dividend,
	input  logic [XLEN-1:0] divisor,
	output rvde_div_stat_t  stat,
	output logic [XLEN-1:0] quotient
);

	typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_DONE} div_state_t;

	localparam int NW = $clog2(XLEN);

	div_state_t      state_q;
	logic [NW-1:0]   cnt_q;
	logic [XLEN-1:0] quo_q, den_q, rem_q;
	logic            neg_q, zero_q;
	logic [XLEN:0]   shifted;
	logic            fits;

	assign shifted = {rem_q, quo_q[XLEN-1]};
	assign fits    = (shifted >= {1'b0, den_q});
	assign stat.idle = (state_q == DIV_IDLE);
	assign stat.done = (state_q == DIV_DONE);
	assign quotient  = zero_q ? '0 : (neg_q ? XLEN'(-quo_q) : quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
			quo_q   <= '0;
			den_q   <= '0;
			rem_q   <= '0;
			neg_q   <= 1'b0;
			zero_q  <= 1'b0;
		end else begin
			unique case (state_q)
				DIV_IDLE: begin
					if (start) begin
						quo_q   <= dividend[XLEN-1] ? XLEN'(-dividend) : dividend;
						den_q   <= divisor[XLEN-1] ? XLEN'(-divisor) : divisor;
						rem_q   <= '0;
						neg_q   <= dividend[XLEN-1] ^ divisor[XLEN-1];
						zero_q  <= (divisor == '0);
						cnt_q   <= NW'(XLEN - 1);
						state_q <= DIV_RUN;
					end
				end
				DIV_RUN: begin
					rem_q <= fits ? XLEN'(shifted - {1'b0, den_q}) : shifted[XLEN-1:0];
					quo_q <= {quo_q[XLEN-2:0], fits};
					if (cnt_q == '0) state_q <= DIV_DONE;
					else cnt_q <= cnt_q - 1'b1;
				end
				DIV_DONE: begin
					if (ack) state_q <= DIV_IDLE;
				end
				default: state_q <= DIV_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/rvde_back.sv */
// back part: executes micro-ops and holds the result beat
module rvde_back import rvde_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	output logic            head_ready,
	input  rvde_uop_t       head,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [111:0]    m_tdata
);

	logic            is_div, load_out, pop, taken, redir;
	logic [XLEN-1:0] alu_res, res;
	logic [4:0]      shamt;
	rvde_div_stat_t  div_stat;
	logic [XLEN-1:0] div_quot;

	logic [XLEN-1:0] res_q, sdata_q, npc_q;
	logic [4:0]      rd_q;
	logic            wr_q, ld_q, st_q, redir_q, valid_q;
	err_t            err_q;

	assign is_div     = (head.alu_op == ALU_DIV);
	assign load_out   = !valid_q || m_tready;
	assign pop        = head_valid && load_out && (!is_div || div_stat.done);
	assign head_ready = pop;
	assign shamt      = head.alu_b[4:0] & SHAMT_MASK;

	rvde_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (head_valid && is_div && div_stat.idle),
		.ack      (pop && is_div),
		.dividend (head.alu_a),
		.divisor  (head.alu_b),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	always_comb begin
		unique case (head.alu_op)
			ALU_ADD: alu_res = head.alu_a + head.alu_b;
			ALU_SUB: alu_res = head.alu_a - head.alu_b;
			ALU_MUL: alu_res = XLEN'(head.alu_a * head.alu_b);
			ALU_SLL: alu_res = head.alu_a << shamt;
			ALU_XOR: alu_res = head.alu_a ^ head.alu_b;
			ALU_DIV: alu_res = div_quot;
			ALU_SRL: alu_res = head.alu_a >> shamt;
			ALU_SRA: alu_res = XLEN'($signed(head.alu_a) >>> shamt);
			ALU_OR:  alu_res = head.alu_a | head.alu_b;
			ALU_AND: alu_res = head.alu_a & head.alu_b;
			default: alu_res = '0;
		endcase
	end

	always_comb begin
		unique case (head.br_cond)
			BR_EQ:  taken = (head.alu_a == head.alu_b);
			BR_NE:  taken = (head.alu_a != head.alu_b);
			BR_LT:  taken = ($signed(head.alu_a) < $signed(head.alu_b));
			BR_GE:  taken = ($signed(head.alu_a) >= $signed(head.alu_b));
			BR_LTU: taken = (head.alu_a < head.alu_b);
			BR_GEU: taken = (head.alu_a >= head.alu_b);
			default: taken = 1'b0;
		endcase
	end

	assign res   = head.is_branch ? '0 : alu_res;
	assign redir = head.is_jump || (head.is_branch && taken);

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q   <= res;
			sdata_q <= head.store_data;
			npc_q   <= redir ? head.target : head.pc_plus4;
			rd_q    <= head.rd;
			wr_q    <= head.writes;
			ld_q    <= head.is_load;
			st_q    <= head.is_store;
			redir_q <= redir;
			err_q   <= head.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {5'b0, err_q, npc_q, redir_q, sdata_q, st_q, ld_q, wr_q, rd_q, res_q};

endmodule

/* rtl/core/rv32_decode_and_execute_top.sv */
// top level of the rv32 decode and execute block
//
// channel  dir  beat fields (tdata, lowest bit first)
// s_axis   in   instr_word, pc_value, src1_value, src2_value
// m_axis   out  alu_result, dest_reg, writes_reg, is_load, is_store,
//               store_data, redirect, next_pc, error_code
//
// one beat per cycle unless a divide or m_tready stalls the back part; the result
// beat is registered; a signed divide holds the back part until the bit-serial divider
// is done; the micro-op queue lets the front keep taking beats while the back waits
// arst_n clears the queue, the divider and the output valid
module rv32_decode_and_execute_top import rvde_pkg::*; #(
	parameter int FIFO_DEPTH = RVDE_FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// instr_word[31:0], pc_value[63:32], src1_value[95:64], src2_value[127:96]
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// alu_result[31:0], dest_reg[36:32], writes_reg[37], is_load[38], is_store[39],
	// store_data[71:40], redirect[72], next_pc[104:73], error_code[106:105]
	output logic [111:0] m_tdata
);

	rvde_uop_t front_uop, head_uop;
	logic      head_valid, head_ready;

	rvde_front u_front (
		.instr_word (s_tdata[31:0]),
		.pc_value   (s_tdata[63:32]),
		.src1_value (s_tdata[95:64]),
		.src2_value (s_tdata[127:96]),
		.uop        (front_uop)
	);

	rvde_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_uop    (front_uop),
		.out_valid (head_valid),
		.out_ready (head_ready),
		.out_uop   (head_uop)
	);

	rvde_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_ready (head_ready),
		.head       (head_uop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

/* sim/rv32_decode_and_execute_top_tb.sv */
// self-checking testbench for the rv32 decode and execute block
`timescale 1ns / 100ps

module rv32_decode_and_execute_top_tb;
	import rvde_pkg::*;

	typedef struct packed {
		logic [31:0] src2;
		logic [31:0] src1;
		logic [31:0] pc;
		logic [31:0] instr;
	} instr_beat_t;

	typedef struct packed {
		logic [4:0]  pad;
		err_t        err;
		logic [31:0] next_pc;
		logic        redirect;
		logic [31:0] store_data;
		logic        is_store;
		logic        is_load;
		logic        writes_reg;
		logic [4:0]  dest_reg;
		logic [31:0] alu_result;
	} exec_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [111:0] m_tdata;

	instr_beat_t pending_instrs[$];
	exec_beat_t expected_results[$];
	int errors = 0;
	int send_idle_pct = 24;
	int recv_idle_pct = 83;
	int hold_off = 0;
	bit send_paused = 1'b0;
	bit stim_done = 1'b0;

	rv32_decode_and_execute_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
		logic [31:0] ua, ub, q;
		ua = a[31] ? -a : a;
		ub = b[31] ? -b : b;
		if (b == 0) return 0;
		q = ua / ub;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic exec_beat_t execute(instr_beat_t x);
		exec_beat_t r;
		logic [6:0] opc, f7;
		logic [2:0] f3;
		logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j;
		logic [4:0] sh;
		bit taken;
		opc = x.instr[6:0];
		f3 = x.instr[14:12];
		f7 = x.instr[31:25];
		a = x.src1;
		imm_i = {{20{x.instr[31]}}, x.instr[31:20]};
		imm_s = {{20{x.instr[31]}}, x.instr[31:25], x.instr[11:7]};
		imm_b = {{19{x.instr[31]}}, x.instr[31], x.instr[7], x.instr[30:25],
			x.instr[11:8], 1'b0};
		imm_j = {{11{x.instr[31]}}, x.instr[31], x.instr[19:12], x.instr[20],
			x.instr[30:21], 1'b0};
		r = '0;
		r.err = ERR_NONE;
		r.next_pc = x.pc + 4;
		taken = 1'b0;
		case (opc)
			OPC_R, OPC_IMM: begin
				b = (opc == OPC_R) ? x.src2 : imm_i;
				if (opc == OPC_IMM) f7 = F7_BASE;
				sh = b[4:0] & SHAMT_MASK;
				r.writes_reg = 1'b1;
				case (f3)
					F3_ADD: begin
						if (f7 == F7_BASE) r.alu_result = a + b;
						else if (f7 == F7_ALT) r.alu_result = a - b;
						else if (f7 == F7_MULD) r.alu_result = a * b;
						else r.err = ERR_FUNCT;
					end
					F3_SLL: r.alu_result = a << sh;
					F3_ADD2: r.alu_result = a + b;
					F3_XOR: r.alu_result = (f7 == F7_MULD) ? sdiv(a, b) : a ^ b;
					F3_SR: r.alu_result = x.instr[30] ? $unsigned($signed(a) >>> sh) : a >> sh;
					F3_OR: r.alu_result = a | b;
					F3_AND: r.alu_result = a & b;
					default: r.err = ERR_FUNCT;
				endcase
			end
			OPC_LOAD: begin
				r.alu_result = a + imm_i;
				r.writes_reg = 1'b1;
				r.is_load = 1'b1;
			end
			OPC_STORE: begin
				r.alu_result = a + imm_s;
				r.is_store = 1'b1;
				r.store_data = x.src2;
			end
			OPC_BRANCH: begin
				case (f3)
					F3_BEQ: taken = a == x.src2;
					F3_BNE: taken = a != x.src2;
					F3_BLT: taken = $signed(a) < $signed(x.src2);
					F3_BGE: taken = $signed(a) >= $signed(x.src2);
					F3_BLTU: taken = a < x.src2;
					F3_BGEU: taken = a >= x.src2;
					default: r.err = ERR_FUNCT;
				endcase
				if (taken) begin
					r.redirect = 1'b1;
					r.next_pc = x.pc + imm_b;
				end
			end
			OPC_LUI: begin
				r.alu_result = {x.instr[31:12], 12'b0};
				r.writes_reg = 1'b1;
			end
			OPC_JAL: begin
				r.alu_result = x.pc + 4;
				r.writes_reg = 1'b1;
				r.redirect = 1'b1;
				r.next_pc = x.pc + imm_j;
			end
			OPC_JALR: begin
				r.alu_result = x.pc + 4;
				r.writes_reg = 1'b1;
				r.redirect = 1'b1;
				r.next_pc = (a + imm_i) & ~32'd1;
			end
			default: r.err = ERR_OPCODE;
		endcase
		if (r.err != ERR_NONE) begin
			r.alu_result = 0;
			r.store_data = 0;
			r.next_pc = x.pc + 4;
			r.writes_reg = 0;
			r.is_load = 0;
			r.is_store = 0;
			r.redirect = 0;
		end
		if (r.writes_reg) r.dest_reg = x.instr[11:7];
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", field, got, want);
		errors++;
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'hffff_ffff;
			2: return $urandom_range(0, 3);
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_instr();
		logic [6:0] opcs[8];
		logic [31:0] w;
		opcs = '{OPC_R, OPC_IMM, OPC_LOAD, OPC_STORE, OPC_BRANCH, OPC_LUI, OPC_JAL, OPC_JALR};
		w = $urandom;
		if ($urandom_range(0, 9) == 0) return w;
		w[6:0] = opcs[$urandom_range(0, 7)];
		if (w[6:0] == OPC_R && $urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 3))
				0: w[31:25] = F7_BASE;
				1: w[31:25] = F7_ALT;
				default: w[31:25] = F7_MULD;
			endcase
		end
		return w;
	endfunction

	task automatic push_instr(logic [31:0] w, logic [31:0] a, logic [31:0] b);
		instr_beat_t x;
		x.instr = w;
		x.pc = $urandom;
		x.src1 = a;
		x.src2 = b;
		pending_instrs.insert(pending_instrs.size(), x);
	endtask

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			expected_results.insert(expected_results.size(), execute(instr_beat_t'(s_tdata)));
		if (!(s_tvalid && !s_tready)) begin
			if (!send_paused && pending_instrs.size() > 0
				&& $urandom_range(0, 99) >= send_idle_pct) begin
				s_tdata <= pending_instrs.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		exec_beat_t got, want;
		if (m_tvalid && m_tready) begin
			got = exec_beat_t'(m_tdata);
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (got.alu_result !== want.alu_result)
					report_mismatch("alu_result", got.alu_result, want.alu_result);
				if (got.dest_reg !== want.dest_reg)
					report_mismatch("dest_reg", got.dest_reg, want.dest_reg);
				if (got.writes_reg !== want.writes_reg)
					report_mismatch("writes_reg", got.writes_reg, want.writes_reg);
				if (got.is_load !== want.is_load)
					report_mismatch("is_load", got.is_load, want.is_load);
				if (got.is_store !== want.is_store)
					report_mismatch("is_store", got.is_store, want.is_store);
				if (got.store_data !== want.store_data)
					report_mismatch("store_data", got.store_data, want.store_data);
				if (got.redirect !== want.redirect)
					report_mismatch("redirect", got.redirect, want.redirect);
				if (got.next_pc !== want.next_pc)
					report_mismatch("next_pc", got.next_pc, want.next_pc);
				if (got.err !== want.err)
					report_mismatch("error_code", got.err, want.err);
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#10_000_000;
		$display("rv32_decode_and_execute_top test failed");
		$finish;
	end

	initial begin
		logic [31:0] w;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// directed: every opcode class, some funct forms, divide corners
		push_instr({F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_R}, 32'h7fff_ffff, 32'd1);
		push_instr({F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_R}, 32'h8000_0000, 32'd1);
		push_instr({F7_MULD, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_R}, 32'hffff_ffff, 32'hffff_ffff);
		push_instr({F7_MULD, 5'd2, 5'd1, F3_XOR, 5'd3, OPC_R}, 32'd7, 32'd0);
		push_instr({F7_MULD, 5'd2, 5'd1, F3_XOR, 5'd3, OPC_R}, 32'h8000_0000, 32'hffff_ffff);
		push_instr({F7_MULD, 5'd2, 5'd1, F3_XOR, 5'd3, OPC_R}, 32'hffff_fff9, 32'd2);
		push_instr({F7_BASE, 5'd2, 5'd1, F3_XOR, 5'd3, OPC_R}, 32'h1234_5678, 32'hffff_0000);
		push_instr({F7_BASE, 5'd2, 5'd1, F3_SLL, 5'd31, OPC_R}, 32'd1, 32'hffff_ffff);
		push_instr({F7_BASE, 5'd2, 5'd1, F3_SR, 5'd4, OPC_R}, 32'h8000_0000, 32'd31);
		push_instr({F7_ALT, 5'd2, 5'd1, F3_SR, 5'd4, OPC_R}, 32'h8000_0000, 32'd31);
		push_instr({7'h7f, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_R}, 32'd1, 32'd1);
		push_instr({F7_BASE, 5'd2, 5'd1, F3_BAD, 5'd3, OPC_R}, 32'd1, 32'd1);
		push_instr({12'hfff, 5'd1, F3_BAD, 5'd3, OPC_IMM}, 32'd1, 32'd1);
		push_instr({12'hfff, 5'd1, F3_AND, 5'd3, OPC_IMM}, 32'hffff_ffff, 32'd0);
		push_instr({12'h800, 5'd1, F3_OR, 5'd3, OPC_LOAD}, 32'd0, 32'd0);
		push_instr({7'h40, 5'd2, 5'd1, F3_ADD2, 5'h1f, OPC_STORE}, 32'd16, 32'hdead_beef);
		push_instr({7'h7f, 5'd2, 5'd1, F3_BEQ, 5'h1f, OPC_BRANCH}, 32'd5, 32'd5);
		push_instr({7'h00, 5'd2, 5'd1, F3_BLTU, 5'h02, OPC_BRANCH}, 32'd1, 32'hffff_ffff);
		push_instr({7'h00, 5'd2, 5'd1, F3_BLT, 5'h02, OPC_BRANCH}, 32'd1, 32'hffff_ffff);
		push_instr({7'h00, 5'd2, 5'd1, F3_BGEU, 5'h02, OPC_BRANCH}, 32'd1, 32'hffff_ffff);
		push_instr({7'h00, 5'd2, 5'd1, F3_BAD, 5'h02, OPC_BRANCH}, 32'd1, 32'd1);
		push_instr({20'hfffff, 5'd9, OPC_LUI}, 32'd0, 32'd0);
		push_instr({20'h80000, 5'd1, OPC_JAL}, 32'd0, 32'd0);
		push_instr({12'h7ff, 5'd1, 3'd0, 5'd1, OPC_JALR}, 32'hffff_ffff, 32'd0);
		push_instr(32'hffff_ffff, 32'd0, 32'd0);
		// random, three idle profiles
		for (int p = 0; p < 3; p++) begin
			wait (pending_instrs.size() == 0);
			if (p == 1) begin
				send_paused = 1'b1;
				wait (expected_results.size() == 0 && !s_tvalid);
				send_idle_pct = 83;
				recv_idle_pct = 24;
				hold_off = 60;
				send_paused = 1'b0;
			end else if (p == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int i = 0; i < 475; i++) begin
				w = rand_instr();
				push_instr(w, rand_operand(), rand_operand());
			end
		end
		wait (pending_instrs.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("rv32_decode_and_execute_top test passed");
		end else begin
			$display("rv32_decode_and_execute_top test failed");
		end
		$finish;
	end

endmodule
